// File: hw/rtl/shebe_pkg.sv
package shebe_pkg;

	localparam int ROUNDS_DEF = 12;
	localparam int TDATA_W = 72;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  cnt;
		logic        fin;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_PAD,
		ST_CMP,
		ST_ADD,
		ST_OUT
	} back_state_t;

	typedef enum logic [1:0] {
		PH_BLOCK,
		PH_PAD,
		PH_N,
		PH_SIGMA
	} phase_t;

	typedef enum logic [1:0] {
		CS_INIT,
		CS_STATE,
		CS_KEY
	} cstep_t;

	localparam logic [7:0] SBOX [256] = '{
		8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
		8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
		8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
		8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
		8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
		8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
		8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
		8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
		8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
		8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
		8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
		8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
		8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
		8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
		8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
		8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
		8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
		8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
		8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
		8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
		8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
		8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
		8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
		8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
		8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
		8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
		8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
		8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
		8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
		8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
		8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
		8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
	};

	localparam logic [63:0] LMAT [64] = '{
		64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
		64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
		64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
		64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
		64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
		64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
		64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
		64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
		64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
		64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
		64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
		64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
		64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
		64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
		64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
		64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
	};

	// word 7 in the top bits, word 0 in the low bits
	localparam logic [511:0] RC [12] = '{
		{64'hb1085bda1ecadae9,64'hebcb2f81c0657c1f,64'h2f6a76432e45d016,64'h714eb88d7585c4fc,
		 64'h4b7ce09192676901,64'ha2422a08a460d315,64'h05767436cc744d23,64'hdd806559f2a64507},
		{64'h6fa3b58aa99d2f1a,64'h4fe39d460f70b5d7,64'hf3feea720a232b98,64'h61d55e0f16b50131,
		 64'h9ab5176b12d69958,64'h5cb561c2db0aa7ca,64'h55dda21bd7cbcd56,64'he679047021b19bb7},
		{64'hf574dcac2bce2fc7,64'h0a39fc286a3d8435,64'h06f15e5f529c1f8b,64'hf2ea7514b1297b7b,
		 64'hd3e20fe490359eb1,64'hc1c93a376062db09,64'hc2b6f443867adb31,64'h991e96f50aba0ab2},
		{64'hef1fdfb3e81566d2,64'hf948e1a05d71e4dd,64'h488e857e335c3c7d,64'h9d721cad685e353f,
		 64'ha9d72c82ed03d675,64'hd8b71333935203be,64'h3453eaa193e837f1,64'h220cbebc84e3d12e},
		{64'h4bea6bacad474799,64'h9a3f410c6ca92363,64'h7f151c1f1686104a,64'h359e35d7800fffbd,
		 64'hbfcd1747253af5a3,64'hdfff00b723271a16,64'h7a56a27ea9ea63f5,64'h601758fd7c6cfe57},
		{64'hae4faeae1d3ad3d9,64'h6fa4c33b7a3039c0,64'h2d66c4f95142a46c,64'h187f9ab49af08ec6,
		 64'hcffaa6b71c9ab7b4,64'h0af21f66c2bec6b6,64'hbf71c57236904f35,64'hfa68407a46647d6e},
		{64'hf4c70e16eeaac5ec,64'h51ac86febf240954,64'h399ec6c7e6bf87c9,64'hd3473e33197a93c9,
		 64'h0992abc52d822c37,64'h06476983284a0504,64'h3517454ca23c4af3,64'h8886564d3a14d493},
		{64'h9b1f5b424d93c9a7,64'h03e7aa020c6e4141,64'h4eb7f8719c36de1e,64'h89b4443b4ddbc49a,
		 64'hf4892bcb929b0690,64'h69d18d2bd1a5c42f,64'h36acc2355951a8d9,64'ha47f0dd4bf02e71e},
		{64'h378f5a541631229b,64'h944c9ad8ec165fde,64'h3a7d3a1b25894224,64'h3cd955b7e00d0984,
		 64'h800a440bdbb2ceb1,64'h7b2b8a9aa6079c54,64'h0e38dc92cb1f2a60,64'h7261445183235adb},
		{64'habbedea680056f52,64'h382ae548b2e4f3f3,64'h8941e71cff8a78db,64'h1fffe18a1b336103,
		 64'h9fe76702af69334b,64'h7a1e6c303b7652f4,64'h3698fad1153bb6c3,64'h74b4c7fb98459ced},
		{64'h7bcd9ed0efc889fb,64'h3002c6cd635afe94,64'hd8fa6bbbebab0761,64'h2001802114846679,
		 64'h8a1d71efea48b9ca,64'hefbacd1d7d476e98,64'hdea2594ac06fd85d,64'h6bcaa4cd81f32d1b},
		{64'h378ee767f11631ba,64'hd21380b00449b17a,64'hcda43c32bcdf1d77,64'hf82012d430219f9b,
		 64'h5d80ef9d1891cc86,64'he71da4aa88e12852,64'hfaf417d5d9b21b99,64'h48bc924af11bd720}
	};

	function automatic logic [63:0] lin(input logic [63:0] v);
		logic [63:0] r;
		r = '0;
		for (int j = 0; j < 64; j++) begin
			if (v[j]) begin
				r = r ^ LMAT[63 - j];
			end
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/streebog_hash_engine_unit.sv
// streebog hash engine
// input channel s_*: one item carries up to eight message bytes, first byte in
// the low bits; valid_bytes gives the count, tlast ends the message. only the
// final item may be short. a two-item queue decouples input from the core.
// output channel m_*: after the final item eight items carry the 512-bit chain
// value, word 0 first, tlast on word 7. the 256-bit mode emits all 512 bits.
// cfg_*: one bit, digest mode (0 = 512-bit start value, 1 = 256-bit). a write
// restarts the message; the user must make it only while idle (not enforced by the block).
// per block: each 64-byte block costs one compression on the single lps unit
// (key set-up plus two lps passes per round for 12 rounds), then the word-serial
// n and sigma adders; a new item is taken only in the idle state. finalisation
// adds padding, three compressions and the eight output items.
// reset clears the state to the 512-bit start value with an empty message.
// a stall on m_tready holds the output register and the core waits; input
// items keep filling the queue until it is full.
module streebog_hash_engine_unit #(
	parameter int ROUNDS = shebe_pkg::ROUNDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [shebe_pkg::TDATA_W-1:0] s_tdata,  // message_word, valid_bytes
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [shebe_pkg::TDATA_W-1:0] m_tdata,  // digest_word, word_index
	output logic                         m_tlast,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data
);

	logic             q_valid;
	logic             q_pop;
	shebe_pkg::item_t q_item;
	logic [63:0]      out_word;
	logic [2:0]       out_idx;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {5'd0, out_idx, out_word};

	shebe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_word  (s_tdata[63:0]),
		.in_cnt   (s_tdata[67:64]),
		.in_fin   (s_tlast),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	shebe_back #(
		.ROUNDS(ROUNDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_mode  (cfg_data),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (out_word),
		.out_idx   (out_idx),
		.out_last  (m_tlast)
	);

endmodule

// File: hw/rtl/shebe_front.sv
module shebe_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [63:0]          in_word,
	input  logic [3:0]           in_cnt,
	input  logic                 in_fin,
	output logic                 q_valid,
	input  logic                 q_pop,
	output shebe_pkg::item_t     q_item
);

	shebe_pkg::item_t mem_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;
	shebe_pkg::item_t it;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rp_q];

	// clamp the byte count to one word
	always_comb begin
		it.word = in_word;
		it.cnt  = (in_cnt > 4'd8) ? 4'd8 : in_cnt;
		it.fin  = in_fin;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= it;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: hw/rtl/shebe_lps.sv
module shebe_lps (
	input  logic [511:0] x,
	output logic [511:0] y
);

	logic [63:0] v [8];

	always_comb begin
		for (int w = 0; w < 8; w++) begin
			for (int k = 0; k < 8; k++) begin
				v[w][k*8 +: 8] = shebe_pkg::SBOX[x[k*64 + w*8 +: 8]];
			end
			y[w*64 +: 64] = shebe_pkg::lin(v[w]);
		end
	end

endmodule

// File: hw/rtl/shebe_back.sv
module shebe_back #(
	parameter int ROUNDS = shebe_pkg::ROUNDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_mode,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  shebe_pkg::item_t     q_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [63:0]          out_word,
	output logic [2:0]           out_idx,
	output logic                 out_last
);

	localparam int RW = $clog2(ROUNDS);

	shebe_pkg::back_state_t state_q, state_d;
	shebe_pkg::phase_t      phase_q;
	shebe_pkg::cstep_t      sub_q;
	logic [RW-1:0]          rnd_q;
	logic                   mode_q;
	logic [6:0]             pos_q;
	logic [63:0]            word_q;
	logic [3:0]             rem_q;
	logic                   fin_q;
	logic [511:0]           buf_q;
	logic [511:0]           h_q, n_q, s_q, key_q, st_q;
	logic [2:0]             wcnt_q;
	logic                   cn_q, cs_q;
	logic [2:0]             oidx_q;

	logic [6:0]   room, take;
	logic [511:0] lps_in, lps_out, msel, nsel, start_val;
	logic         cmp_done, add_done, out_load;
	logic [63:0]  addend;
	logic [64:0]  sum_n, sum_s;

	shebe_lps u_lps (
		.x(lps_in),
		.y(lps_out)
	);

	assign room      = 7'd64 - pos_q;
	assign take      = ({3'd0, rem_q} < room) ? {3'd0, rem_q} : room;
	assign start_val = mode_q ? {64{8'h01}} : '0;

	always_comb begin
		unique case (phase_q)
			shebe_pkg::PH_N:     msel = n_q;
			shebe_pkg::PH_SIGMA: msel = s_q;
			default:             msel = buf_q;
		endcase
		nsel = (phase_q == shebe_pkg::PH_N || phase_q == shebe_pkg::PH_SIGMA) ? '0 : n_q;
		unique case (sub_q)
			shebe_pkg::CS_STATE: lps_in = st_q;
			shebe_pkg::CS_KEY:   lps_in = key_q ^ shebe_pkg::RC[rnd_q];
			default:             lps_in = h_q ^ nsel;
		endcase
	end

	always_comb begin
		addend = (wcnt_q == 3'd0) ? {54'd0, pos_q, 3'd0} : '0;
		sum_n  = {1'b0, n_q[wcnt_q*64 +: 64]} + {1'b0, addend} + {64'd0, cn_q};
		sum_s  = {1'b0, s_q[wcnt_q*64 +: 64]} + {1'b0, buf_q[wcnt_q*64 +: 64]} + {64'd0, cs_q};
	end

	always_comb begin
		q_pop    = (state_q == shebe_pkg::ST_IDLE) && q_valid;
		cmp_done = (state_q == shebe_pkg::ST_CMP) && (sub_q == shebe_pkg::CS_KEY)
			&& (rnd_q == RW'(ROUNDS - 1));
		add_done = (state_q == shebe_pkg::ST_ADD) && (wcnt_q == 3'd7);
		out_load = (state_q == shebe_pkg::ST_OUT) && (!out_valid || out_ready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			shebe_pkg::ST_IDLE: begin
				if (q_valid) state_d = shebe_pkg::ST_ACC;
			end
			shebe_pkg::ST_ACC: begin
				if (pos_q + take == 7'd64) state_d = shebe_pkg::ST_CMP;
				else if (fin_q) state_d = shebe_pkg::ST_PAD;
				else state_d = shebe_pkg::ST_IDLE;
			end
			shebe_pkg::ST_PAD: state_d = shebe_pkg::ST_CMP;
			shebe_pkg::ST_CMP: begin
				if (cmp_done) begin
					unique case (phase_q)
						shebe_pkg::PH_N:     state_d = shebe_pkg::ST_CMP;
						shebe_pkg::PH_SIGMA: state_d = shebe_pkg::ST_OUT;
						default:             state_d = shebe_pkg::ST_ADD;
					endcase
				end
			end
			shebe_pkg::ST_ADD: begin
				if (add_done) begin
					state_d = (phase_q == shebe_pkg::PH_PAD) ? shebe_pkg::ST_CMP
						: shebe_pkg::ST_ACC;
				end
			end
			shebe_pkg::ST_OUT: begin
				if (out_load && oidx_q == 3'd7) state_d = shebe_pkg::ST_IDLE;
			end
			default: state_d = shebe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			word_q <= q_item.word;
			fin_q  <= q_item.fin;
		end
		if (state_q == shebe_pkg::ST_ACC) begin
			for (int k = 0; k < 64; k++) begin
				if (7'(k) >= pos_q && 7'(k) - pos_q < take) begin
					buf_q[k*8 +: 8] <= word_q[(7'(k) - pos_q) * 8 +: 8];
				end
			end
			word_q <= word_q >> {take[3:0], 3'd0};
		end
		if (state_q == shebe_pkg::ST_PAD) begin
			for (int k = 0; k < 64; k++) begin
				if (7'(k) == pos_q) buf_q[k*8 +: 8] <= 8'h01;
				else if (7'(k) > pos_q) buf_q[k*8 +: 8] <= 8'h00;
			end
		end
		if (state_q == shebe_pkg::ST_CMP) begin
			unique case (sub_q)
				shebe_pkg::CS_STATE: st_q <= lps_out;
				shebe_pkg::CS_KEY: begin
					key_q <= lps_out;
					st_q  <= st_q ^ lps_out;
				end
				default: begin
					key_q <= lps_out;
					st_q  <= msel ^ lps_out;
				end
			endcase
		end
		if (out_load) begin
			out_word <= h_q[oidx_q*64 +: 64];
			out_idx  <= oidx_q;
			out_last <= (oidx_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= shebe_pkg::ST_IDLE;
			phase_q   <= shebe_pkg::PH_BLOCK;
			sub_q     <= shebe_pkg::CS_INIT;
			rnd_q     <= '0;
			mode_q    <= 1'b0;
			pos_q     <= '0;
			rem_q     <= '0;
			h_q       <= '0;
			n_q       <= '0;
			s_q       <= '0;
			wcnt_q    <= '0;
			cn_q      <= 1'b0;
			cs_q      <= 1'b0;
			oidx_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				rem_q <= q_item.cnt;
			end
			if (state_q == shebe_pkg::ST_ACC) begin
				pos_q <= pos_q + take;
				rem_q <= rem_q - take[3:0];
				if (pos_q + take == 7'd64) phase_q <= shebe_pkg::PH_BLOCK;
			end
			if (state_q == shebe_pkg::ST_PAD) begin
				phase_q <= shebe_pkg::PH_PAD;
			end
			if (state_d == shebe_pkg::ST_CMP && (state_q != shebe_pkg::ST_CMP || cmp_done)) begin
				sub_q <= shebe_pkg::CS_INIT;
				rnd_q <= '0;
			end else if (state_q == shebe_pkg::ST_CMP) begin
				if (sub_q == shebe_pkg::CS_KEY) begin
					sub_q <= shebe_pkg::CS_STATE;
					rnd_q <= rnd_q + RW'(1);
				end else begin
					sub_q <= (sub_q == shebe_pkg::CS_INIT) ? shebe_pkg::CS_STATE
						: shebe_pkg::CS_KEY;
				end
			end
			if (cmp_done) begin
				h_q <= h_q ^ st_q ^ lps_out ^ msel;
				if (phase_q == shebe_pkg::PH_N) phase_q <= shebe_pkg::PH_SIGMA;
				wcnt_q <= '0;
				cn_q   <= 1'b0;
				cs_q   <= 1'b0;
				oidx_q <= '0;
			end
			if (state_q == shebe_pkg::ST_ADD) begin
				n_q[wcnt_q*64 +: 64] <= sum_n[63:0];
				s_q[wcnt_q*64 +: 64] <= sum_s[63:0];
				cn_q   <= sum_n[64];
				cs_q   <= sum_s[64];
				wcnt_q <= wcnt_q + 3'd1;
				if (add_done) begin
					if (phase_q == shebe_pkg::PH_PAD) phase_q <= shebe_pkg::PH_N;
					else pos_q <= '0;
				end
			end
			if (out_load) begin
				out_valid <= 1'b1;
				oidx_q    <= oidx_q + 3'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			// start a new message after the last word or a mode write
			if ((out_load && oidx_q == 3'd7) || cfg_we) begin
				h_q   <= cfg_we ? (cfg_mode ? {64{8'h01}} : '0) : start_val;
				n_q   <= '0;
				s_q   <= '0;
				pos_q <= '0;
			end
			if (cfg_we) begin
				mode_q <= cfg_mode;
			end
		end
	end

endmodule

// File: bench/streebog_hash_engine_unit_test.sv
module streebog_hash_engine_unit_test;

	typedef logic [63:0] blk_t [8];

	typedef struct {
		logic [63:0] word;
		logic [3:0]  cnt;
		logic        fin;
		logic        chk;
		logic [63:0] dig0;
	} stim_row_t;

	typedef struct {
		logic [63:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_item_t;

	localparam logic [7:0] S_BOX [256] = '{
		8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
		8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
		8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
		8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
		8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
		8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
		8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
		8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
		8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
		8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
		8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
		8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
		8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
		8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
		8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
		8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
		8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
		8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
		8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
		8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
		8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
		8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
		8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
		8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
		8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
		8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
		8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
		8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
		8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
		8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
		8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
		8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
	};

	localparam logic [63:0] MIX_ROWS [64] = '{
		64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
		64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
		64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
		64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
		64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
		64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
		64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
		64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
		64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
		64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
		64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
		64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
		64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
		64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
		64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
		64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
	};

	localparam logic [63:0] ROUND_KEYS [12][8] = '{
		'{64'hdd806559f2a64507,64'h05767436cc744d23,64'ha2422a08a460d315,64'h4b7ce09192676901,
		  64'h714eb88d7585c4fc,64'h2f6a76432e45d016,64'hebcb2f81c0657c1f,64'hb1085bda1ecadae9},
		'{64'he679047021b19bb7,64'h55dda21bd7cbcd56,64'h5cb561c2db0aa7ca,64'h9ab5176b12d69958,
		  64'h61d55e0f16b50131,64'hf3feea720a232b98,64'h4fe39d460f70b5d7,64'h6fa3b58aa99d2f1a},
		'{64'h991e96f50aba0ab2,64'hc2b6f443867adb31,64'hc1c93a376062db09,64'hd3e20fe490359eb1,
		  64'hf2ea7514b1297b7b,64'h06f15e5f529c1f8b,64'h0a39fc286a3d8435,64'hf574dcac2bce2fc7},
		'{64'h220cbebc84e3d12e,64'h3453eaa193e837f1,64'hd8b71333935203be,64'ha9d72c82ed03d675,
		  64'h9d721cad685e353f,64'h488e857e335c3c7d,64'hf948e1a05d71e4dd,64'hef1fdfb3e81566d2},
		'{64'h601758fd7c6cfe57,64'h7a56a27ea9ea63f5,64'hdfff00b723271a16,64'hbfcd1747253af5a3,
		  64'h359e35d7800fffbd,64'h7f151c1f1686104a,64'h9a3f410c6ca92363,64'h4bea6bacad474799},
		'{64'hfa68407a46647d6e,64'hbf71c57236904f35,64'h0af21f66c2bec6b6,64'hcffaa6b71c9ab7b4,
		  64'h187f9ab49af08ec6,64'h2d66c4f95142a46c,64'h6fa4c33b7a3039c0,64'hae4faeae1d3ad3d9},
		'{64'h8886564d3a14d493,64'h3517454ca23c4af3,64'h06476983284a0504,64'h0992abc52d822c37,
		  64'hd3473e33197a93c9,64'h399ec6c7e6bf87c9,64'h51ac86febf240954,64'hf4c70e16eeaac5ec},
		'{64'ha47f0dd4bf02e71e,64'h36acc2355951a8d9,64'h69d18d2bd1a5c42f,64'hf4892bcb929b0690,
		  64'h89b4443b4ddbc49a,64'h4eb7f8719c36de1e,64'h03e7aa020c6e4141,64'h9b1f5b424d93c9a7},
		'{64'h7261445183235adb,64'h0e38dc92cb1f2a60,64'h7b2b8a9aa6079c54,64'h800a440bdbb2ceb1,
		  64'h3cd955b7e00d0984,64'h3a7d3a1b25894224,64'h944c9ad8ec165fde,64'h378f5a541631229b},
		'{64'h74b4c7fb98459ced,64'h3698fad1153bb6c3,64'h7a1e6c303b7652f4,64'h9fe76702af69334b,
		  64'h1fffe18a1b336103,64'h8941e71cff8a78db,64'h382ae548b2e4f3f3,64'habbedea680056f52},
		'{64'h6bcaa4cd81f32d1b,64'hdea2594ac06fd85d,64'hefbacd1d7d476e98,64'h8a1d71efea48b9ca,
		  64'h2001802114846679,64'hd8fa6bbbebab0761,64'h3002c6cd635afe94,64'h7bcd9ed0efc889fb},
		'{64'h48bc924af11bd720,64'hfaf417d5d9b21b99,64'he71da4aa88e12852,64'h5d80ef9d1891cc86,
		  64'hf82012d430219f9b,64'hcda43c32bcdf1d77,64'hd21380b00449b17a,64'h378ee767f11631ba}
	};

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [shebe_pkg::TDATA_W-1:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [shebe_pkg::TDATA_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;

	logic mode_shadow;
	blk_t chain_h, len_n, sum_sigma, msg_blk;
	int unsigned held_bytes;
	digest_item_t digest_q[$];
	int errors;
	int send_idle_pct;
	int recv_stall_pct;
	logic [63:0] first_word_expect;
	logic first_word_armed;

	streebog_hash_engine_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#80000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic blk_t lps_xform(blk_t x);
		blk_t t;
		logic [63:0] v, r;
		for (int w = 0; w < 8; w++) begin
			v = '0;
			for (int k = 0; k < 8; k++) begin
				v[8*k +: 8] = S_BOX[x[k][8*w +: 8]];
			end
			r = '0;
			for (int j = 0; j < 64; j++) begin
				if (v[j]) begin
					r = r ^ MIX_ROWS[63-j];
				end
			end
			t[w] = r;
		end
		return t;
	endfunction

	function automatic blk_t add_mod512(blk_t a, blk_t b);
		logic [64:0] s;
		logic c;
		c = 1'b0;
		for (int i = 0; i < 8; i++) begin
			s = {1'b0, a[i]} + {1'b0, b[i]} + {64'd0, c};
			a[i] = s[63:0];
			c = s[64];
		end
		return a;
	endfunction

	function automatic blk_t gost_compress(blk_t h, blk_t n, blk_t m);
		blk_t k, st;
		for (int i = 0; i < 8; i++) begin
			k[i] = h[i] ^ n[i];
		end
		k = lps_xform(k);
		for (int i = 0; i < 8; i++) begin
			st[i] = m[i] ^ k[i];
		end
		for (int r = 0; r < 12; r++) begin
			st = lps_xform(st);
			for (int i = 0; i < 8; i++) begin
				k[i] = k[i] ^ ROUND_KEYS[r][i];
			end
			k = lps_xform(k);
			for (int i = 0; i < 8; i++) begin
				st[i] = st[i] ^ k[i];
			end
		end
		for (int i = 0; i < 8; i++) begin
			h[i] = h[i] ^ st[i] ^ m[i];
		end
		return h;
	endfunction

	task automatic restart_message();
		for (int i = 0; i < 8; i++) begin
			chain_h[i] = mode_shadow ? 64'h0101010101010101 : 64'h0;
			len_n[i] = '0;
			sum_sigma[i] = '0;
			msg_blk[i] = '0;
		end
		held_bytes = 0;
	endtask

	task automatic hash_absorb(logic [63:0] word, logic [3:0] cnt, logic fin);
		blk_t zero, blen, full;
		int unsigned n;
		zero = '{default: '0};
		full = '{default: '0};
		full[0] = 64'd512;
		n = (cnt > 4'd8) ? 8 : int'(cnt);
		for (int i = 0; i < n; i++) begin
			msg_blk[held_bytes / 8][8*(held_bytes % 8) +: 8] = word[8*i +: 8];
			held_bytes++;
			if (held_bytes >= 64) begin
				chain_h = gost_compress(chain_h, len_n, msg_blk);
				len_n = add_mod512(len_n, full);
				sum_sigma = add_mod512(sum_sigma, msg_blk);
				held_bytes = 0;
			end
		end
		if (fin) begin
			blen = '{default: '0};
			blen[0] = 64'(held_bytes * 8);
			msg_blk[held_bytes / 8][8*(held_bytes % 8) +: 8] = 8'h01;
			for (int i = held_bytes + 1; i < 64; i++) begin
				msg_blk[i / 8][8*(i % 8) +: 8] = 8'h00;
			end
			chain_h = gost_compress(chain_h, len_n, msg_blk);
			len_n = add_mod512(len_n, blen);
			sum_sigma = add_mod512(sum_sigma, msg_blk);
			chain_h = gost_compress(chain_h, zero, len_n);
			chain_h = gost_compress(chain_h, zero, sum_sigma);
			for (int i = 0; i < 8; i++) begin
				digest_q.push_back('{word: chain_h[i], idx: 3'(i), last: (i == 7)});
			end
			restart_message();
		end
	endtask

	task automatic send_item(logic [63:0] word, logic [3:0] cnt, logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, cnt, word};
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		hash_absorb(word, cnt, fin);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (digest_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (150) @(posedge clk);
	endtask

	task automatic write_mode(logic v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		mode_shadow = v;
		restart_message();
	endtask

	task automatic random_message(int words);
		for (int i = 0; i < words; i++) begin
			send_item({$urandom, $urandom}, 4'd8, 1'b0);
		end
		send_item({$urandom, $urandom}, 4'($urandom_range(15)), 1'b1);
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		digest_item_t e;
		if (m_tvalid && m_tready) begin
			if (digest_q.size() == 0) begin
				errors++;
				$display("%0t unexpected item %h", $time, m_tdata);
			end else begin
				e = digest_q.pop_front();
				if (m_tdata[63:0] !== e.word || m_tdata[66:64] !== e.idx
						|| m_tlast !== e.last) begin
					errors++;
					$display("%0t expected %h/%0d/%b got %h/%0d/%b", $time, e.word,
						e.idx, e.last, m_tdata[63:0], m_tdata[66:64], m_tlast);
				end
				if (first_word_armed && e.idx == 0) begin
					first_word_armed = 1'b0;
					if (m_tdata[63:0] !== first_word_expect) begin
						errors++;
						$display("%0t expected %h got %h", $time, first_word_expect,
							m_tdata[63:0]);
					end
				end
			end
		end
	end

	stim_row_t rows [20];

	initial begin
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		first_word_armed = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		mode_shadow = 1'b0;
		restart_message();
		rows = '{
			'{64'h0, 4'd0, 1'b1, 1'b0, 64'h0},
			'{64'hffffffffffffffff, 4'd8, 1'b0, 1'b0, 64'h0},
			'{64'h0000000000000000, 4'd8, 1'b0, 1'b0, 64'h0},
			'{64'h8000000000000001, 4'd3, 1'b1, 1'b0, 64'h0},
			'{64'hffffffffffffffff, 4'd15, 1'b1, 1'b0, 64'h0},
			'{64'h0123456789abcdef, 4'd9, 1'b0, 1'b0, 64'h0},
			'{64'hfedcba9876543210, 4'd1, 1'b0, 1'b0, 64'h0},
			'{64'h5555555555555555, 4'd7, 1'b0, 1'b0, 64'h0},
			'{64'haaaaaaaaaaaaaaaa, 4'd8, 1'b1, 1'b0, 64'h0},
			'{64'h1, 4'd4, 1'b0, 1'b0, 64'h0},
			'{64'h2, 4'd2, 1'b0, 1'b0, 64'h0},
			'{64'h3, 4'd6, 1'b0, 1'b0, 64'h0},
			'{64'h4, 4'd5, 1'b0, 1'b0, 64'h0},
			'{64'h5, 4'd0, 1'b0, 1'b0, 64'h0},
			'{64'h6, 4'd8, 1'b1, 1'b0, 64'h0},
			'{64'h0, 4'd0, 1'b1, 1'b0, 64'h0},
			'{64'hffffffffffffffff, 4'd8, 1'b0, 1'b0, 64'h0},
			'{64'hffffffffffffffff, 4'd8, 1'b0, 1'b0, 64'h0},
			'{64'hffffffffffffffff, 4'd8, 1'b0, 1'b0, 64'h0},
			'{64'hffffffffffffffff, 4'd0, 1'b1, 1'b0, 64'h0}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[r]) begin
			if (rows[r].chk) begin
				first_word_expect = rows[r].dig0;
				first_word_armed = 1'b1;
			end
			send_item(rows[r].word, rows[r].cnt, rows[r].fin);
		end
		// full block exactly at the end, then padding-only block
		for (int i = 0; i < 8; i++) begin
			send_item({$urandom, $urandom}, 4'd8, (i == 7));
		end
		write_mode(1'b1);
		send_item(64'h0, 4'd0, 1'b1);
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			write_mode(p[0]);
			for (int m = 0; m < 9; m++) begin
				random_message(($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(9));
			end
			wait_drained();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_mode(1'b0);
		wait_drained();
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/shebe_pkg.sv
hw/rtl/shebe_front.sv
hw/rtl/shebe_lps.sv
hw/rtl/shebe_back.sv
hw/rtl/streebog_hash_engine_unit.sv
bench/streebog_hash_engine_unit_test.sv
